// ===== sv/tal_pkg.sv =====
// shared types and constants for the tracking area list parser
package tal_pkg;

  localparam logic [7:0] LIST_CNT_MAX = 8'd255;
  localparam logic [1:0] TYPE_RESERVED = 2'd3;
  localparam logic [1:0] TYPE_SEPARATE = 2'd0;
  localparam logic [1:0] TYPE_MULTI_PLMN = 2'd2;
  localparam logic [1:0] ELEM_LAST_BYTE = 2'd2;
  localparam logic [3:0] NIBBLE_FILLER = 4'hf;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_PLMN,
    PH_TAC
  } tal_phase_t;

  // one parsed record as it travels from front to back
  typedef struct packed {
    logic [7:0]  list_number;
    logic [1:0]  list_type;
    logic [5:0]  element_count;
    logic [4:0]  element_index;
    logic [23:0] plmn;
    logic [23:0] area_code;
    logic        area_code_valid;
    logic        truncated;
    logic        last;
  } tal_rec_t;

endpackage

// ===== sv/tal_front.sv =====
// byte parser: walks head, plmn and tac bytes and builds result records
module tal_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              end_of_data,
  output logic              rec_push,
  output tal_pkg::tal_rec_t rec
);
  import tal_pkg::*;

  tal_phase_t  phase_r, phase_nxt;
  logic [1:0]  byte_pos_r, byte_pos_nxt;
  logic [1:0]  type_r, type_nxt;
  logic [5:0]  count_r, count_nxt;
  logic [5:0]  remain_r, remain_nxt;
  logic [7:0]  list_cnt_r, list_cnt_nxt;
  logic [23:0] plmn_r, plmn_nxt;
  logic [23:0] code_r, code_nxt;

  logic        accept;
  logic        byte_last;
  logic [23:0] plmn_shift;
  logic [23:0] code_shift;
  logic [5:0]  remain_dec;
  logic [5:0]  head_count;
  logic [5:0]  idx_diff;
  logic [4:0]  idx_cur;
  tal_phase_t  tac_done_phase;
  logic        emit;

  assign accept     = in_valid && in_ready;
  assign byte_last  = (byte_pos_r == ELEM_LAST_BYTE);
  assign plmn_shift = {plmn_r[15:0], data_byte};
  assign code_shift = {code_r[15:0], data_byte};
  assign remain_dec = (remain_r != 6'd0) ? (remain_r - 6'd1) : remain_r;
  assign head_count = {1'b0, data_byte[4:0]} + 6'd1;
  assign idx_diff   = count_r - remain_r;
  // types 1 and 3 always report element 0
  assign idx_cur    = type_r[0] ? 5'd0 : idx_diff[4:0];

  always_comb begin
    if (type_r == TYPE_SEPARATE) begin
      tac_done_phase = (remain_dec != 6'd0) ? PH_TAC : PH_HEAD;
    end else if (type_r == TYPE_MULTI_PLMN) begin
      tac_done_phase = (remain_dec != 6'd0) ? PH_PLMN : PH_HEAD;
    end else begin
      tac_done_phase = PH_HEAD;
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (end_of_data) begin
      phase_nxt = PH_HEAD;
    end else begin
      unique case (phase_r)
        PH_HEAD: phase_nxt = PH_PLMN;
        PH_PLMN: begin
          if (byte_last) begin
            phase_nxt = (type_r == TYPE_RESERVED) ? PH_HEAD : PH_TAC;
          end
        end
        PH_TAC: begin
          if (byte_last) begin
            phase_nxt = tac_done_phase;
          end
        end
        default: phase_nxt = PH_HEAD;
      endcase
    end
  end

  // datapath registers
  always_comb begin
    byte_pos_nxt = byte_pos_r;
    type_nxt     = type_r;
    count_nxt    = count_r;
    remain_nxt   = remain_r;
    list_cnt_nxt = list_cnt_r;
    plmn_nxt     = plmn_r;
    code_nxt     = code_r;
    if (end_of_data) begin
      byte_pos_nxt = 2'd0;
      type_nxt     = 2'd0;
      count_nxt    = 6'd1;
      remain_nxt   = 6'd0;
      list_cnt_nxt = 8'd0;
      plmn_nxt     = 24'd0;
      code_nxt     = 24'd0;
    end else begin
      unique case (phase_r)
        PH_HEAD: begin
          if (list_cnt_r != LIST_CNT_MAX) begin
            list_cnt_nxt = list_cnt_r + 8'd1;
          end
          type_nxt     = data_byte[6:5];
          count_nxt    = head_count;
          remain_nxt   = head_count;
          byte_pos_nxt = 2'd0;
          plmn_nxt     = 24'd0;
          code_nxt     = 24'd0;
        end
        PH_PLMN: begin
          plmn_nxt = plmn_shift;
          if (byte_last) begin
            byte_pos_nxt = 2'd0;
            code_nxt     = 24'd0;
          end else begin
            byte_pos_nxt = byte_pos_r + 2'd1;
          end
        end
        PH_TAC: begin
          if (byte_last) begin
            byte_pos_nxt = 2'd0;
            remain_nxt   = remain_dec;
            code_nxt     = 24'd0;
            if (tac_done_phase == PH_PLMN) begin
              plmn_nxt = 24'd0;
            end
          end else begin
            byte_pos_nxt = byte_pos_r + 2'd1;
            code_nxt     = code_shift;
          end
        end
        default: byte_pos_nxt = 2'd0;
      endcase
    end
  end

  // record outputs
  always_comb begin
    emit                = 1'b0;
    rec                 = '0;
    rec.list_number     = list_cnt_r;
    rec.list_type       = type_r;
    rec.element_count   = count_r;
    rec.element_index   = idx_cur;
    rec.last            = end_of_data;
    unique case (phase_r)
      PH_HEAD: begin
        emit              = end_of_data;
        rec.list_number   = (list_cnt_r != LIST_CNT_MAX) ? (list_cnt_r + 8'd1) : list_cnt_r;
        rec.list_type     = data_byte[6:5];
        rec.element_count = head_count;
        rec.element_index = 5'd0;
        rec.truncated     = 1'b1;
      end
      PH_PLMN: begin
        if (byte_last && (type_r == TYPE_RESERVED)) begin
          emit          = 1'b1;
          rec.plmn      = plmn_shift;
          rec.truncated = 1'b0;
        end else begin
          emit          = end_of_data;
          rec.truncated = 1'b1;
        end
      end
      PH_TAC: begin
        if (byte_last) begin
          emit                = 1'b1;
          rec.plmn            = plmn_r;
          rec.area_code       = code_shift;
          rec.area_code_valid = 1'b1;
          rec.truncated       = end_of_data && (tac_done_phase != PH_HEAD);
        end else begin
          emit          = end_of_data;
          rec.truncated = 1'b1;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  assign rec_push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEAD;
      byte_pos_r <= 2'd0;
      type_r     <= 2'd0;
      count_r    <= 6'd1;
      remain_r   <= 6'd0;
      list_cnt_r <= 8'd0;
      plmn_r     <= 24'd0;
      code_r     <= 24'd0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      byte_pos_r <= byte_pos_nxt;
      type_r     <= type_nxt;
      count_r    <= count_nxt;
      remain_r   <= remain_nxt;
      list_cnt_r <= list_cnt_nxt;
      plmn_r     <= plmn_nxt;
      code_r     <= code_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_head_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEAD) |-> (byte_pos_r == 2'd0))
    else $error("byte position not cleared at head");

  a_eod_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && end_of_data) |=> (phase_r == PH_HEAD && list_cnt_r == 8'd0))
    else $error("parser did not restart after final byte");

  a_trunc_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (rec_push && rec.truncated) |-> rec.last)
    else $error("truncation record without last");
`endif

endmodule

// ===== sv/tal_fifo.sv =====
// two-entry record queue between parser and output stage
module tal_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tal_pkg::tal_rec_t push_rec,
  output logic              not_full,
  input  logic              pop,
  output logic              not_empty,
  output tal_pkg::tal_rec_t pop_rec
);
  import tal_pkg::*;

  tal_rec_t   mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign not_full   = (cnt_r != 2'd2);
  assign not_empty  = (cnt_r != 2'd0);
  assign pop_rec    = mem[rd_ptr_r];
  assign wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
  assign rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== sv/tal_back.sv =====
// output stage: unpacks bcd digits and holds the result register
module tal_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            rec_valid,
  input  tal_pkg::tal_rec_t               rec,
  output logic                            rec_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tal_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tlast
);
  import tal_pkg::*;

  logic                  valid_r;
  logic [OUT_DATA_W-1:0] data_r, data_nxt;
  logic                  last_r;
  logic [7:0]            b1, b2, b3;
  logic [11:0]           mcc, mnc;
  logic                  two_digit;

  assign b1 = rec.plmn[23:16];
  assign b2 = rec.plmn[15:8];
  assign b3 = rec.plmn[7:0];
  assign mcc       = {b1[3:0], b1[7:4], b2[3:0]};
  assign mnc       = {b3[3:0], b3[7:4], b2[7:4]};
  assign two_digit = (b2[7:4] == NIBBLE_FILLER);

  assign data_nxt = {rec.truncated, rec.area_code_valid, rec.area_code, two_digit,
                     mnc, mcc, rec.element_index, rec.element_count,
                     rec.list_type, rec.list_number};

  assign rec_pop    = rec_valid && (!valid_r || out_tready);
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      data_r <= data_nxt;
      last_r <= rec.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (rec_pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

endmodule

// ===== sv/tracking_area_list_parser.sv =====
// tracking area list parser: one list byte per transfer, one record per finished element or cut-short list
// throughput: one input byte every cycle while the record queue has room
// a finished record goes into the queue, then into the output register that drives out_tvalid
// a two-entry queue and the output register let the front keep taking bytes while
// a result waits; reset (rst_n low, synchronous) empties both and restarts at a head byte
module tracking_area_list_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_data
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] list_number, [9:8] list_type, [15:10] element_count, [20:16] element_index,
  // [32:21] mcc_digits, [44:33] mnc_digits, [45] mnc_two_digit, [69:46] area_code,
  // [70] area_code_valid, [71] truncated
  output logic [71:0] out_tdata,
  output logic        out_tlast   // last
);
  import tal_pkg::*;

  logic     push;
  tal_rec_t push_rec;
  logic     q_not_full;
  logic     q_not_empty;
  logic     pop;
  tal_rec_t pop_rec;

  assign in_tready = q_not_full;

  tal_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (q_not_full),
    .data_byte   (in_tdata),
    .end_of_data (in_tlast),
    .rec_push    (push),
    .rec         (push_rec)
  );

  tal_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .not_full  (q_not_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_rec   (pop_rec)
  );

  tal_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_valid  (q_not_empty),
    .rec        (pop_rec),
    .rec_pop    (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== verif/tracking_area_list_parser_test.sv =====
`timescale 1ns / 100ps
// self-checking bench for the tracking area list parser: byte streams in, parsed records checked
module tracking_area_list_parser_test;
  import tal_pkg::*;

  localparam logic [1:0] TYPE_CONSECUTIVE = 2'd1;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RUN_LISTS = 110;

  // out_tlast on top, then out_tdata from its highest field down
  typedef struct packed {
    logic        last;
    logic        truncated;
    logic        area_code_valid;
    logic [23:0] area_code;
    logic        mnc_two_digit;
    logic [11:0] mnc_digits;
    logic [11:0] mcc_digits;
    logic [4:0]  element_index;
    logic [5:0]  element_count;
    logic [1:0]  list_type;
    logic [7:0]  list_number;
  } tai_record_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        out_tlast;

  tracking_area_list_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  // parser state as the predictor sees it
  tal_phase_t  parse_phase;
  logic [1:0]  byte_pos;
  logic [1:0]  cur_type;
  logic [5:0]  elem_count;
  logic [5:0]  elems_left;
  logic [7:0]  list_no;
  logic [23:0] plmn_reg;
  logic [23:0] tac_reg;

  tai_record_t pending_records[$];
  int          mismatch_count = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;

  task automatic clear_parse_state();
    parse_phase = PH_HEAD;
    byte_pos = 2'd0;
    cur_type = TYPE_SEPARATE;
    elem_count = 6'd1;
    elems_left = 6'd0;
    list_no = 8'd0;
    plmn_reg = 24'd0;
    tac_reg = 24'd0;
  endtask

  function automatic logic [4:0] index_now();
    if (cur_type == TYPE_CONSECUTIVE || cur_type == TYPE_RESERVED) return 5'd0;
    return 5'(elem_count - elems_left);
  endfunction

  task automatic push_record(input logic [4:0] idx, input logic with_plmn,
                             input logic [23:0] tac, input logic valid,
                             input logic trunc, input logic last);
    tai_record_t r;
    r = '0;
    r.list_number = list_no;
    r.list_type = cur_type;
    r.element_count = elem_count;
    r.element_index = idx;
    if (with_plmn) begin
      // nibbles swap inside each byte; mnc digit 3 sits in the middle byte
      r.mcc_digits = {plmn_reg[19:16], plmn_reg[23:20], plmn_reg[11:8]};
      r.mnc_digits = {plmn_reg[3:0], plmn_reg[7:4], plmn_reg[15:12]};
      r.mnc_two_digit = (plmn_reg[15:12] == NIBBLE_FILLER);
    end
    r.area_code = tac;
    r.area_code_valid = valid;
    r.truncated = trunc;
    r.last = last;
    pending_records.push_back(r);
  endtask

  task automatic track_byte(input logic [7:0] b, input logic eod);
    tal_phase_t next_phase;
    logic [4:0] idx;
    case (parse_phase)
      PH_HEAD: begin
        if (list_no != LIST_CNT_MAX) list_no = list_no + 8'd1;
        cur_type = b[6:5];
        elem_count = {1'b0, b[4:0]} + 6'd1;
        elems_left = elem_count;
        byte_pos = 2'd0;
        plmn_reg = 24'd0;
        tac_reg = 24'd0;
        parse_phase = PH_PLMN;
        if (eod) push_record(5'd0, 1'b0, 24'd0, 1'b0, 1'b1, 1'b1);
      end
      PH_PLMN: begin
        plmn_reg = {plmn_reg[15:0], b};
        if (byte_pos != ELEM_LAST_BYTE) begin
          byte_pos = byte_pos + 2'd1;
          if (eod) push_record(index_now(), 1'b0, 24'd0, 1'b0, 1'b1, 1'b1);
        end else begin
          byte_pos = 2'd0;
          tac_reg = 24'd0;
          if (cur_type == TYPE_RESERVED) begin
            push_record(5'd0, 1'b1, 24'd0, 1'b0, 1'b0, eod);
            parse_phase = PH_HEAD;
          end else begin
            parse_phase = PH_TAC;
            if (eod) push_record(index_now(), 1'b0, 24'd0, 1'b0, 1'b1, 1'b1);
          end
        end
      end
      default: begin
        tac_reg = {tac_reg[15:0], b};
        if (byte_pos != ELEM_LAST_BYTE) begin
          byte_pos = byte_pos + 2'd1;
          if (eod) push_record(index_now(), 1'b0, 24'd0, 1'b0, 1'b1, 1'b1);
        end else begin
          idx = index_now();
          byte_pos = 2'd0;
          if (elems_left != 6'd0) elems_left = elems_left - 6'd1;
          if (cur_type == TYPE_SEPARATE)
            next_phase = (elems_left != 6'd0) ? PH_TAC : PH_HEAD;
          else if (cur_type == TYPE_MULTI_PLMN)
            next_phase = (elems_left != 6'd0) ? PH_PLMN : PH_HEAD;
          else
            next_phase = PH_HEAD;
          push_record(idx, 1'b1, tac_reg, 1'b1, eod && next_phase != PH_HEAD, eod);
          if (next_phase == PH_PLMN) plmn_reg = 24'd0;
          tac_reg = 24'd0;
          parse_phase = next_phase;
        end
      end
    endcase
    if (eod) clear_parse_state();
  endtask

  function automatic string describe(tai_record_t r);
    return {$sformatf("list %0d type %0d count %0d index %0d mcc %03h mnc %03h two %0b",
                      r.list_number, r.list_type, r.element_count, r.element_index,
                      r.mcc_digits, r.mnc_digits, r.mnc_two_digit),
            $sformatf(" tac %06h valid %0b trunc %0b last %0b",
                      r.area_code, r.area_code_valid, r.truncated, r.last)};
  endfunction

  // prediction on input transfers, checking on output transfers, sink stalls, watchdog
  always @(posedge clk) begin : monitor
    tai_record_t got;
    tai_record_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) track_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got = {out_tlast, out_tdata};
        if (pending_records.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected record: %s", describe(got));
        end else begin
          want = pending_records.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("record mismatch, expected: %s", describe(want));
              $display("                   actual: %s", describe(got));
            end
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    if (stall_left > 0) stall_left = stall_left - 1;
    else if (!calm && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 3);
    out_tready <= (stall_left == 0);
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge where the byte is taken
  task automatic send_byte(input logic [7:0] b, input logic eod);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      in_tdata <= 8'($urandom);
      in_tlast <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eod;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [7:0] list_byte();
    logic [7:0] v;
    v = 8'($urandom);
    if ($urandom_range(0, 3) == 0) v[7:4] = NIBBLE_FILLER;
    return v;
  endfunction

  task automatic test_directed_cases();
    // spare bit set, reserved type, largest count, data ends on the head
    send_byte({1'b1, TYPE_RESERVED, 5'h1f}, 1'b1);
    // separate tacs, one element, two-digit mnc, all-ones tac
    send_byte({1'b0, TYPE_SEPARATE, 5'd0}, 1'b0);
    send_byte(8'h21, 1'b0);
    send_byte(8'hf3, 1'b0);
    send_byte(8'h54, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    // consecutive tacs, count 32, zero plmn, data ends inside the tac
    send_byte({1'b0, TYPE_CONSECUTIVE, 5'h1f}, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b1);
    // multiple plmns: the element ends on the final byte with one more announced
    send_byte({1'b0, TYPE_MULTI_PLMN, 5'd1}, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'hab, 1'b0);
    send_byte(8'hcd, 1'b0);
    send_byte(8'hef, 1'b1);
    // reserved type completing on the final byte
    send_byte({1'b0, TYPE_RESERVED, 5'd0}, 1'b0);
    send_byte(8'h99, 1'b0);
    send_byte(8'hf9, 1'b0);
    send_byte(8'h99, 1'b1);
    // data ends inside the plmn
    send_byte({1'b0, TYPE_SEPARATE, 5'd2}, 1'b0);
    send_byte(8'h47, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  task automatic test_random_lists(input int byte_budget);
    logic [7:0] ie[$];
    logic [4:0] cnt;
    logic [1:0] kind;
    int         body;
    int         style;
    int         cut;
    int         sent;
    sent = 0;
    while (sent < byte_budget) begin
      ie.delete();
      repeat ($urandom_range(1, 4)) begin
        kind = 2'($urandom_range(0, 3));
        // mostly short lists, now and then up to the full 32 elements
        cnt = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(0, 3));
        ie.push_back({1'($urandom_range(0, 1)), kind, cnt});
        case (kind)
          TYPE_SEPARATE:    body = 3 + 3 * (int'(cnt) + 1);
          TYPE_CONSECUTIVE: body = 6;
          TYPE_MULTI_PLMN:  body = 6 * (int'(cnt) + 1);
          default:          body = 3;
        endcase
        repeat (body) ie.push_back(list_byte());
      end
      style = $urandom_range(0, 9);
      if (style == 9) begin
        // raw noise with scattered end marks
        repeat ($urandom_range(1, 12)) begin
          send_byte(8'($urandom), $urandom_range(0, 7) == 0);
          sent++;
        end
      end else begin
        // cut short now and then; one style runs on into the next element without an end
        if (style >= 7) begin
          cut = $urandom_range(1, ie.size());
          while (ie.size() > cut) void'(ie.pop_back());
        end
        foreach (ie[i]) send_byte(ie[i], (i == ie.size() - 1) && style != 6);
        sent += ie.size();
      end
    end
  endtask

  task automatic test_list_number_run();
    calm = 1'b1;
    // resync the parser to a head byte whatever came before
    send_byte(8'h00, 1'b1);
    // many reserved lists back to back so the list number climbs high
    for (int k = 0; k < RUN_LISTS; k++) begin
      send_byte({1'($urandom_range(0, 1)), TYPE_RESERVED, 5'($urandom)}, 1'b0);
      for (int j = 0; j < 3; j++)
        send_byte(list_byte(), (k == RUN_LISTS - 1) && (j == 2));
    end
  endtask

  initial begin
    clear_parse_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_lists(250);
    test_list_number_run();
    in_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_records.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tal_pkg.sv
sv/tal_front.sv
sv/tal_fifo.sv
sv/tal_back.sv
sv/tracking_area_list_parser.sv
verif/tracking_area_list_parser_test.sv
